// ===== src/adcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcr_pkg
// Types and constants shared by the two-wire converter readout block.
// ----------------------------------------------------------------------------
package adcr_pkg;

  // transaction kind held while the bus is busy
  typedef enum logic [1:0] {
    BUSY_IDLE  = 2'd0,
    BUSY_SETUP = 2'd1,
    BUSY_READ  = 2'd2
  } busy_kind_e;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_SETUP  = 3'd0;
  localparam logic [2:0] REG_MIN_EDGE_GAP  = 3'd1;
  localparam logic [2:0] REG_HOLDOFF_TICKS = 3'd2;
  localparam logic [2:0] REG_RESULT_SHIFT  = 3'd3;
  localparam logic [2:0] REG_DEADBAND      = 3'd4;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned OUT_BITS      = 24;

  // reset values of the configuration registers
  localparam logic [7:0]  RST_DEVICE_SETUP  = 8'd24;
  localparam logic [23:0] RST_MIN_EDGE_GAP  = 24'd15000;
  localparam logic [23:0] RST_HOLDOFF_TICKS = 24'd10000;
  localparam logic [4:0]  RST_RESULT_SHIFT  = 5'd6;
  localparam logic [7:0]  RST_DEADBAND      = 8'd2;

  // setup write framing
  localparam logic [7:0] CMD_BYTE     = 8'hCA;
  localparam int unsigned LEAD_CLOCKS  = 27;
  localparam int unsigned EXTRA_CLOCKS = 3;

  // result of the sample post-processing
  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                update;
  } adcr_sample_t;

endpackage
`default_nettype wire

// ===== src/adcr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcr_in_if / adcr_out_if
// Valid/ready channels for tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface adcr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink   (input valid, input line_level, output ready);
endinterface

interface adcr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clock_level;
  logic                          data_drive;
  logic                          data_enable;
  logic                          sample_valid;
  logic signed [adcr_pkg::OUT_BITS-1:0] sample_value;
  logic signed [adcr_pkg::OUT_BITS-1:0] reported_value;
  logic                          is_configured;

  modport source (output valid, output clock_level, output data_drive, output data_enable,
                  output sample_valid, output sample_value, output reported_value,
                  output is_configured, input ready);
  modport sink   (input valid, input clock_level, input data_drive, input data_enable,
                  input sample_valid, input sample_value, input reported_value,
                  input is_configured, output ready);
endinterface
`default_nettype wire

// ===== src/adcr_sample_proc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcr_sample_proc
// Sign extension, arithmetic shift and deadband decision for one reading.
// ----------------------------------------------------------------------------
module adcr_sample_proc #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic [SAMPLE_BITS-1:0]       raw_i,
  input  wire logic [4:0]                   shift_i,
  input  wire logic [7:0]                   deadband_i,
  input  wire logic [adcr_pkg::OUT_BITS-1:0] reported_i,
  output adcr_pkg::adcr_sample_t             result_o
);

  localparam int unsigned OB = adcr_pkg::OUT_BITS;
  localparam int unsigned W  = (SAMPLE_BITS > OB) ? SAMPLE_BITS : OB;

  logic signed [SAMPLE_BITS-1:0] raw_s;
  logic signed [W-1:0]           ext;
  logic signed [W-1:0]           shifted;
  logic [OB-1:0]                 nv;
  logic signed [OB:0]            diff;
  logic [OB:0]                   absd;

  always_comb begin
    raw_s   = $signed(raw_i);
    ext     = W'(raw_s);
    shifted = ext >>> shift_i;
    nv      = shifted[OB-1:0];
    // difference of two 24-bit signed values fits in 25 bits
    diff    = $signed({reported_i[OB-1], reported_i}) - $signed({nv[OB-1], nv});
    absd    = diff[OB] ? (OB+1)'(-diff) : (OB+1)'(diff);
    result_o.value  = nv;
    result_o.update = (absd >= {{(OB+1-8){1'b0}}, deadband_i});
  end

endmodule
`default_nettype wire

// ===== src/adc_two_wire_serial_reader.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_two_wire_serial_reader
// Two-wire master for a sigma-delta converter: setup write, then sample reads.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_i     in   line_level, the sampled data line for one half-clock tick
//  out_o    out  clock/data line drive, sample strobe, sample, reported value
//  cfg      in   write enable, register index, write data (no read-back)
//
//  every input beat produces exactly one output beat; one beat per cycle while out_o takes each beat
//  all work for a tick is done in the cycle the beat is accepted and lands in
//  the output register, so the next beat can follow immediately
//  in_i.ready drops only while a finished beat sits unclaimed in out_o
//  reset is asynchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module adc_two_wire_serial_reader #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  adcr_in_if.sink                                  in_i,
  adcr_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [adcr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [adcr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned OB    = adcr_pkg::OUT_BITS;
  localparam int unsigned CMP_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // clock indexes of the setup-write framing
  localparam logic [5:0] C_TURN   = 6'(adcr_pkg::LEAD_CLOCKS);
  localparam logic [5:0] C_CMD    = 6'(adcr_pkg::LEAD_CLOCKS + 2);
  localparam logic [5:0] C_HOLD   = 6'(adcr_pkg::LEAD_CLOCKS + 9);
  localparam logic [5:0] C_SETUP  = 6'(adcr_pkg::LEAD_CLOCKS + 10);
  localparam logic [5:0] C_REL    = 6'(adcr_pkg::LEAD_CLOCKS + 18);
  // read framing
  localparam logic [5:0] C_RD_END = 6'(SAMPLE_BITS);
  localparam logic [5:0] C_RD_FIN = 6'(SAMPLE_BITS + adcr_pkg::EXTRA_CLOCKS - 1);

  // configuration registers
  logic [7:0]  device_setup_q;
  logic [23:0] min_edge_gap_q;
  logic [23:0] holdoff_ticks_q;
  logic [4:0]  result_shift_q;
  logic [7:0]  deadband_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_setup_q  <= adcr_pkg::RST_DEVICE_SETUP;
      min_edge_gap_q  <= adcr_pkg::RST_MIN_EDGE_GAP;
      holdoff_ticks_q <= adcr_pkg::RST_HOLDOFF_TICKS;
      result_shift_q  <= adcr_pkg::RST_RESULT_SHIFT;
      deadband_q      <= adcr_pkg::RST_DEADBAND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adcr_pkg::REG_DEVICE_SETUP:  device_setup_q  <= cfg_data_i[7:0];
        adcr_pkg::REG_MIN_EDGE_GAP:  min_edge_gap_q  <= cfg_data_i[23:0];
        adcr_pkg::REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_data_i[23:0];
        adcr_pkg::REG_RESULT_SHIFT:  result_shift_q  <= cfg_data_i[4:0];
        adcr_pkg::REG_DEADBAND:      deadband_q      <= cfg_data_i[7:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // transaction state
  adcr_pkg::busy_kind_e   busy_q, busy_d;
  logic [6:0]             phase_q, phase_d;
  logic                   configured_q, configured_d;
  logic [SAMPLE_BITS-1:0] capture_q, capture_d;
  logic [7:0]             shift_out_q, shift_out_d;
  logic [COUNT_BITS-1:0]  gap_cnt_q, gap_cnt_d;
  logic [COUNT_BITS-1:0]  holdoff_q, holdoff_d;
  logic                   prev_level_q, prev_level_d;
  logic [OB-1:0]          reported_q, reported_d;
  logic [OB-1:0]          last_sample_q, last_sample_d;

  // output register
  logic          out_valid_q;
  logic          clk_lvl_q, drive_q, enable_q, smp_valid_q, cfgd_q;
  logic [OB-1:0] smp_value_q, rep_value_q;

  logic accept;
  logic lvl;
  logic [5:0] clk_idx;
  logic low_tick;
  logic clk_lvl, drv, en, smp_valid, done, edge_ok;
  logic [COUNT_BITS-1:0] holdoff_load;

  adcr_pkg::adcr_sample_t proc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign lvl        = in_i.line_level;
  assign clk_idx    = phase_q[6:1];
  assign low_tick   = phase_q[0];

  // post-processing of the capture word as it stands after this tick
  adcr_sample_proc #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_proc (
    .raw_i     (capture_d),
    .shift_i   (result_shift_q),
    .deadband_i(deadband_q),
    .reported_i(reported_q),
    .result_o  (proc)
  );

  // hold-off load saturates to the counter range
  assign holdoff_load = (CMP_W'(holdoff_ticks_q) > CMP_W'(COUNT_MAX)) ?
                        COUNT_MAX : COUNT_BITS'(holdoff_ticks_q);

  assign edge_ok = prev_level_q && !lvl && (holdoff_q == '0) &&
                   (CMP_W'(gap_cnt_q) >= CMP_W'(min_edge_gap_q));

  always_comb begin
    busy_d        = busy_q;
    phase_d       = phase_q;
    configured_d  = configured_q;
    capture_d     = capture_q;
    shift_out_d   = shift_out_q;
    holdoff_d     = holdoff_q;
    reported_d    = reported_q;
    last_sample_d = last_sample_q;
    prev_level_d  = lvl;
    clk_lvl       = 1'b0;
    drv           = 1'b0;
    en            = 1'b0;
    smp_valid     = 1'b0;
    done          = 1'b0;
    gap_cnt_d     = (gap_cnt_q == COUNT_MAX) ? gap_cnt_q : gap_cnt_q + 1'b1;

    unique case (busy_q)
      adcr_pkg::BUSY_SETUP: begin
        clk_lvl = !low_tick;
        if (clk_idx < C_TURN) begin
          en = 1'b0;                       // lead-in clocks, line released
        end else if (clk_idx < C_CMD) begin
          en = 1'b1;                       // turnaround, drive low
        end else if (clk_idx < C_HOLD) begin
          en  = 1'b1;                      // command bits msb first
          drv = shift_out_q[7];
          if (low_tick) shift_out_d = {shift_out_q[6:0], 1'b0};
        end else if (clk_idx < C_SETUP) begin
          en  = 1'b1;                      // hold last command bit
          drv = adcr_pkg::CMD_BYTE[1];
          if (low_tick) shift_out_d = device_setup_q;
        end else if (clk_idx < C_REL) begin
          en  = 1'b1;                      // setup byte msb first
          drv = shift_out_q[7];
          if (low_tick) shift_out_d = {shift_out_q[6:0], 1'b0};
        end else begin
          en = 1'b0;                       // final clock, line released
          if (low_tick) begin
            configured_d = 1'b1;
            done         = 1'b1;
          end
        end
      end
      adcr_pkg::BUSY_READ: begin
        clk_lvl = !low_tick;
        if (low_tick && (clk_idx < C_RD_END)) begin
          capture_d = {capture_q[SAMPLE_BITS-2:0], lvl};
        end
        if (low_tick && (clk_idx >= C_RD_FIN)) begin
          last_sample_d = proc.value;
          if (proc.update) reported_d = proc.value;
          smp_valid = 1'b1;
          done      = 1'b1;
        end
      end
      default: begin
        busy_d = adcr_pkg::BUSY_IDLE;
        if (edge_ok) begin
          busy_d      = configured_q ? adcr_pkg::BUSY_READ : adcr_pkg::BUSY_SETUP;
          phase_d     = '0;
          shift_out_d = adcr_pkg::CMD_BYTE;
          capture_d   = '0;
          gap_cnt_d   = '0;
        end else if (holdoff_q != '0) begin
          holdoff_d = holdoff_q - 1'b1;
        end
      end
    endcase

    if (busy_q == adcr_pkg::BUSY_SETUP || busy_q == adcr_pkg::BUSY_READ) begin
      if (done) begin
        busy_d    = adcr_pkg::BUSY_IDLE;
        phase_d   = '0;
        holdoff_d = holdoff_load;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
  end

  // state advances only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= adcr_pkg::BUSY_IDLE;
      phase_q       <= '0;
      configured_q  <= 1'b0;
      capture_q     <= '0;
      shift_out_q   <= '0;
      gap_cnt_q     <= COUNT_MAX;
      holdoff_q     <= '0;
      prev_level_q  <= 1'b1;
      reported_q    <= '0;
      last_sample_q <= '0;
    end else if (accept) begin
      busy_q        <= busy_d;
      phase_q       <= phase_d;
      configured_q  <= configured_d;
      capture_q     <= capture_d;
      shift_out_q   <= shift_out_d;
      gap_cnt_q     <= gap_cnt_d;
      holdoff_q     <= holdoff_d;
      prev_level_q  <= prev_level_d;
      reported_q    <= reported_d;
      last_sample_q <= last_sample_d;
    end
  end

  // output beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      clk_lvl_q   <= clk_lvl;
      drive_q     <= drv & en;
      enable_q    <= en;
      smp_valid_q <= smp_valid;
      smp_value_q <= last_sample_d;
      rep_value_q <= reported_d;
      cfgd_q      <= configured_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.clock_level    = clk_lvl_q;
  assign out_o.data_drive     = drive_q;
  assign out_o.data_enable    = enable_q;
  assign out_o.sample_valid   = smp_valid_q;
  assign out_o.sample_value   = $signed(smp_value_q);
  assign out_o.reported_value = $signed(rep_value_q);
  assign out_o.is_configured  = cfgd_q;

endmodule
`default_nettype wire

// ===== src/adcr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcr_checker
// Port-level checks for the converter readout block, bound to the top level.
// ----------------------------------------------------------------------------
module adcr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          data_drive,
  input wire logic                          data_enable,
  input wire logic                          sample_valid,
  input wire logic [adcr_pkg::OUT_BITS-1:0] sample_value,
  input wire logic                          is_configured
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(data_drive))
    else $error("stalled result beat changed");

  // data line driven only with enable
  a_drive_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !data_enable |-> !data_drive)
    else $error("data driven without enable");

  // reads happen only after setup
  a_read_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && sample_valid |-> is_configured)
    else $error("sample before setup write");

  // master drives the data line only during the setup write
  a_en_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && data_enable |-> !is_configured)
    else $error("data line driven after setup");

endmodule

bind adc_two_wire_serial_reader adcr_checker u_adcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .data_drive   (out_o.data_drive),
  .data_enable  (out_o.data_enable),
  .sample_valid (out_o.sample_valid),
  .sample_value (out_o.sample_value),
  .is_configured(out_o.is_configured)
);
`default_nettype wire

// ===== verif/adcr_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcr_line_checker
// Watches the tick and result channels and the register port of the readout
// block. It keeps its own copy of the bus sequencer and the sample filter,
// predicts one result beat per accepted tick and compares each result beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module adcr_line_checker #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  adcr_in_if                                 in_mon,
  adcr_out_if                                out_mon,
  input  logic                               cfg_we_i,
  input  logic [adcr_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [adcr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 reads_o
);

  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef struct packed {
    logic                          clock_level;
    logic                          data_drive;
    logic                          data_enable;
    logic                          sample_valid;
    logic [adcr_pkg::OUT_BITS-1:0] sample_value;
    logic [adcr_pkg::OUT_BITS-1:0] reported_value;
    logic                          is_configured;
  } line_beat_t;

  // register copies
  logic [7:0]              setup_byte;
  logic [23:0]             min_gap;
  logic [23:0]             holdoff_len;
  logic [4:0]              shift_amt;
  logic [7:0]              dead_band;

  // sequencer and filter copies
  adcr_pkg::busy_kind_e          busy;
  logic [6:0]                    phase;
  logic                          configured;
  logic [SAMPLE_BITS-1:0]        capture;
  logic [7:0]                    out_sh;
  logic [COUNT_BITS-1:0]         gap_cnt;
  logic [COUNT_BITS-1:0]         hold_cnt;
  logic                          prev_lvl;
  logic [adcr_pkg::OUT_BITS-1:0] reported;
  logic [adcr_pkg::OUT_BITS-1:0] last_smp;

  line_beat_t              beats_due[$];

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // one half-clock tick of the bus sequencer
  task automatic predict_line_tick(input logic lvl, output line_beat_t beat);
    logic [5:0] clk_no;
    logic       low_half;
    logic       drv;
    logic       done;
    logic       accepted;
    longint     wide;
    longint     nv;
    longint     rep;
    longint     diff;
    clk_no   = phase[6:1];
    low_half = phase[0];
    drv      = 1'b0;
    done     = 1'b0;
    accepted = 1'b0;
    beat     = '0;
    if (busy == adcr_pkg::BUSY_SETUP || busy == adcr_pkg::BUSY_READ) begin
      beat.clock_level = !low_half;
      if (busy == adcr_pkg::BUSY_SETUP) begin
        if (clk_no < adcr_pkg::LEAD_CLOCKS) begin
          beat.data_enable = 1'b0;
        end else if (clk_no < adcr_pkg::LEAD_CLOCKS + 2) begin
          beat.data_enable = 1'b1;
        end else if (clk_no < adcr_pkg::LEAD_CLOCKS + 9) begin
          beat.data_enable = 1'b1;
          drv = out_sh[7];
          if (low_half) out_sh = out_sh << 1;
        end else if (clk_no == adcr_pkg::LEAD_CLOCKS + 9) begin
          beat.data_enable = 1'b1;
          drv = adcr_pkg::CMD_BYTE[1];
          if (low_half) out_sh = setup_byte;
        end else if (clk_no < adcr_pkg::LEAD_CLOCKS + 18) begin
          beat.data_enable = 1'b1;
          drv = out_sh[7];
          if (low_half) out_sh = out_sh << 1;
        end else if (low_half) begin
          configured = 1'b1;
          done = 1'b1;
        end
      end else begin
        if (low_half && clk_no < SAMPLE_BITS)
          capture = {capture[SAMPLE_BITS-2:0], lvl};
        if (low_half && clk_no >= SAMPLE_BITS + adcr_pkg::EXTRA_CLOCKS - 1) begin
          wide     = $signed(capture);
          wide     = wide >>> shift_amt;
          last_smp = wide[adcr_pkg::OUT_BITS-1:0];
          nv       = $signed(last_smp);
          rep      = $signed(reported);
          diff     = rep - nv;
          if (diff < 0) diff = -diff;
          if (diff >= dead_band) reported = last_smp;
          beat.sample_valid = 1'b1;
          done = 1'b1;
        end
      end
      if (done) begin
        busy     = adcr_pkg::BUSY_IDLE;
        phase    = '0;
        hold_cnt = (longint'(holdoff_len) > COUNT_MAX) ? '1 : holdoff_len;
      end else begin
        phase = phase + 7'd1;
      end
    end else begin
      busy = adcr_pkg::BUSY_IDLE;
      if (prev_lvl && !lvl && hold_cnt == '0 && gap_cnt >= min_gap) begin
        accepted = 1'b1;
        busy     = configured ? adcr_pkg::BUSY_READ : adcr_pkg::BUSY_SETUP;
        phase    = '0;
        out_sh   = adcr_pkg::CMD_BYTE;
        capture  = '0;
      end else if (hold_cnt != '0) begin
        hold_cnt = hold_cnt - 1'b1;
      end
    end
    if (accepted) gap_cnt = '0;
    else if (gap_cnt != '1) gap_cnt = gap_cnt + 1'b1;
    prev_lvl = lvl;
    beat.data_drive     = beat.data_enable & drv;
    beat.sample_value   = last_smp;
    beat.reported_value = reported;
    beat.is_configured  = configured;
  endtask

  always @(posedge clk_i) begin
    line_beat_t due;
    line_beat_t beat;
    if (!rst_ni) begin
      setup_byte   = adcr_pkg::RST_DEVICE_SETUP;
      min_gap      = adcr_pkg::RST_MIN_EDGE_GAP;
      holdoff_len  = adcr_pkg::RST_HOLDOFF_TICKS;
      shift_amt    = adcr_pkg::RST_RESULT_SHIFT;
      dead_band    = adcr_pkg::RST_DEADBAND;
      busy         = adcr_pkg::BUSY_IDLE;
      phase        = '0;
      configured   = 1'b0;
      capture      = '0;
      out_sh       = '0;
      gap_cnt      = '1;
      hold_cnt     = '0;
      prev_lvl     = 1'b1;
      reported     = '0;
      last_smp     = '0;
      fail_count_o = 0;
      reads_o      = 0;
      beats_due.delete();
    end else begin
      // result side first: a beat leaving now belongs to an earlier tick
      if (out_mon.valid && out_mon.ready) begin
        if (beats_due.size() == 0) begin
          flag_mismatch("result beat with nothing due", 1, 0);
        end else begin
          due = beats_due.pop_front();
          if (out_mon.clock_level !== due.clock_level)
            flag_mismatch("clock_level", out_mon.clock_level, due.clock_level);
          if (out_mon.data_drive !== due.data_drive)
            flag_mismatch("data_drive", out_mon.data_drive, due.data_drive);
          if (out_mon.data_enable !== due.data_enable)
            flag_mismatch("data_enable", out_mon.data_enable, due.data_enable);
          if (out_mon.sample_valid !== due.sample_valid)
            flag_mismatch("sample_valid", out_mon.sample_valid, due.sample_valid);
          if (out_mon.sample_value !== due.sample_value)
            flag_mismatch("sample_value", out_mon.sample_value, $signed(due.sample_value));
          if (out_mon.reported_value !== due.reported_value)
            flag_mismatch("reported_value", out_mon.reported_value,
                          $signed(due.reported_value));
          if (out_mon.is_configured !== due.is_configured)
            flag_mismatch("is_configured", out_mon.is_configured, due.is_configured);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          adcr_pkg::REG_DEVICE_SETUP:  setup_byte  = cfg_data_i[7:0];
          adcr_pkg::REG_MIN_EDGE_GAP:  min_gap     = cfg_data_i[23:0];
          adcr_pkg::REG_HOLDOFF_TICKS: holdoff_len = cfg_data_i[23:0];
          adcr_pkg::REG_RESULT_SHIFT:  shift_amt   = cfg_data_i[4:0];
          adcr_pkg::REG_DEADBAND:      dead_band   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_line_tick(in_mon.line_level, beat);
        beats_due.push_back(beat);
        if (beat.sample_valid) reads_o++;
      end
    end
    pending_o = beats_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-wire converter readout block. Sends data
// line ticks with random gaps against a randomly stalling result side, walks
// the setup write, framed reads and ignored edges through several register
// settings, and leaves checking to the line checker and the bound port checks.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned COUNT_BITS    = 24;
  localparam int unsigned IDX_BITS      = adcr_pkg::CFG_IDX_BITS;
  localparam int unsigned DATA_BITS     = adcr_pkg::CFG_DATA_BITS;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          RANDOM_PHASES = 4;
  localparam int          PHASE_TICKS   = 80;
  localparam int          QUIET_PHASE   = 3;
  localparam int          IDLE_PCT      = 33;
  // ticks of one setup write and of one read after the start edge
  localparam int          SETUP_TICKS   = 2 * (adcr_pkg::LEAD_CLOCKS + 19);
  localparam int          READ_TICKS    = 2 * (SAMPLE_BITS + adcr_pkg::EXTRA_CLOCKS);
  localparam logic [23:0] TICKS_MAX     = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [IDX_BITS-1:0]  cfg_idx;
  logic [DATA_BITS-1:0] cfg_data;
  logic                 quiet;     // no idling on either side while set

  int fail_count;
  int pending;
  int reads_done;
  int ticks_sent  = 0;
  int reg_writes  = 0;
  int cycle_count = 0;
  // timing registers as last written, used only to shape the frames
  int gap_now;
  int hold_now;

  adcr_in_if  in_ch ();
  adcr_out_if out_ch ();

  adc_two_wire_serial_reader #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  adcr_line_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_line_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .reads_o      (reads_done)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // hard stop in case the block hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side stalls about a third of the time, never in the quiet phase
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // one tick beat, with random idle cycles ahead of it
  task automatic send_tick(input logic lvl);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.line_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait for every due result beat
  task automatic drain_line();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                           input logic [DATA_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic set_timing(input logic [23:0] gap, input logic [23:0] hold);
    write_reg(adcr_pkg::REG_MIN_EDGE_GAP, gap);
    write_reg(adcr_pkg::REG_HOLDOFF_TICKS, hold);
    gap_now  = int'(gap);
    hold_now = int'(hold);
  endtask

  // line high, falling edge, then a full read with the word on the low ticks
  task automatic send_read_frame(input logic [SAMPLE_BITS-1:0] word);
    send_tick(1'b1);
    send_tick(1'b0);
    for (int c = 0; c < SAMPLE_BITS + adcr_pkg::EXTRA_CLOCKS; c++) begin
      send_tick(1'($urandom_range(1)));
      send_tick((c < SAMPLE_BITS) ? word[SAMPLE_BITS-1-c] : 1'($urandom_range(1)));
    end
  endtask

  // mostly clean reads spaced past gap and hold-off, then early edges and noise
  task automatic random_frame();
    int pick;
    int lead;
    pick = $urandom_range(99);
    lead = ((hold_now > gap_now) ? hold_now : gap_now) + 1 + $urandom_range(3);
    if (pick < 70) begin
      repeat (lead) send_tick(1'b1);
      send_read_frame(SAMPLE_BITS'($urandom()));
    end else if (pick < 85) begin
      repeat ($urandom_range(lead)) send_tick(1'b1);
      send_tick(1'b0);
      repeat ($urandom_range(1, READ_TICKS)) send_tick(1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(1, 30)) send_tick(1'($urandom_range(1)));
    end
  endtask

  initial begin
    int phase_start;
    int db;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    quiet            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.line_level = 1'b1;
    gap_now          = int'(adcr_pkg::RST_MIN_EDGE_GAP);
    hold_now         = int'(adcr_pkg::RST_HOLDOFF_TICKS);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // indexes past the last register must change nothing
    for (int i = int'(adcr_pkg::REG_DEADBAND) + 1; i < (1 << IDX_BITS); i++)
      write_reg(IDX_BITS'(i), '1);

    // setup write: the gap counter starts saturated, so even the largest
    // gap lets the first edge through and then blocks every later one
    write_reg(adcr_pkg::REG_DEVICE_SETUP, DATA_BITS'($urandom_range(255)));
    set_timing(TICKS_MAX, 24'd0);
    repeat (2) send_tick(1'b1);
    send_tick(1'b0);
    repeat (SETUP_TICKS) send_tick(1'($urandom_range(1)));
    repeat (3) begin
      send_tick(1'b1);
      send_tick(1'b0);
    end
    send_tick(1'b1);

    // back-to-back reads of the extreme words, no shift, no deadband
    drain_line();
    set_timing(24'd0, 24'd0);
    write_reg(adcr_pkg::REG_RESULT_SHIFT, 24'd0);
    write_reg(adcr_pkg::REG_DEADBAND, 24'd0);
    send_read_frame(24'h7FFFFF);
    send_read_frame(24'h800000);
    send_read_frame(24'hFFFFFF);
    send_read_frame(24'h000000);

    // widest shift inside the sample width, then a shift past the sample width
    drain_line();
    write_reg(adcr_pkg::REG_RESULT_SHIFT, 24'd23);
    send_read_frame(24'h7FFFFF);
    send_read_frame(24'h800000);
    drain_line();
    write_reg(adcr_pkg::REG_RESULT_SHIFT, 24'd31);
    send_read_frame(24'h800000);
    send_read_frame(24'h7FFFFF);

    // widest deadband: a small step holds the value, a big one moves it
    drain_line();
    write_reg(adcr_pkg::REG_RESULT_SHIFT, 24'd0);
    write_reg(adcr_pkg::REG_DEADBAND, 24'd255);
    send_read_frame(24'h000010);
    send_read_frame(24'h400000);

    // hold-off swallows an edge right after a read, the gap swallows none later
    drain_line();
    set_timing(24'd80, 24'd20);
    repeat (30) send_tick(1'b1);
    send_read_frame(SAMPLE_BITS'($urandom()));
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (25) send_tick(1'b1);
    send_tick(1'b0);
    repeat (READ_TICKS) send_tick(1'($urandom_range(1)));

    // random phases, each with fresh settings; every phase boundary drains
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_line();
      set_timing(24'($urandom_range(100)), 24'($urandom_range(40)));
      write_reg(adcr_pkg::REG_RESULT_SHIFT,
                DATA_BITS'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                   : $urandom_range(23)));
      case ($urandom_range(3))
        0:       db = 0;
        1:       db = 255;
        default: db = $urandom_range(64);
      endcase
      write_reg(adcr_pkg::REG_DEADBAND, DATA_BITS'(db));
      write_reg(adcr_pkg::REG_DEVICE_SETUP, DATA_BITS'($urandom_range(255)));
      quiet <= (p == QUIET_PHASE);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) random_frame();
    end
    quiet <= 1'b0;

    // longest hold-off: after this read every edge is ignored
    drain_line();
    set_timing(24'd0, TICKS_MAX);
    send_read_frame(SAMPLE_BITS'($urandom()));
    repeat (3) begin
      send_tick(1'b1);
      send_tick(1'b0);
    end
    repeat (4) send_tick(1'b1);

    drain_line();
    repeat (8) @(posedge clk);
    $display("covered %0d line ticks and %0d finished reads over %0d register writes",
             ticks_sent, reads_done, reg_writes);
    $display("incl. the setup write, edges lost to gap and hold-off, shifts up to 31");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
